// File: rtl/circular_deque_core_defines.svh
// Assertion macros for the circular deque core.
`ifndef CIRCULAR_DEQUE_CORE_DEFINES_SVH
`define CIRCULAR_DEQUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define CDQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("circular deque check failed");
// Next-cycle implication, checked out of reset.
`define CDQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("circular deque check failed");
`else
`define CDQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CDQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/cdq_pkg.sv
// Shared constants, opcodes and types of the circular deque core.
package cdq_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 11;
    localparam int CMP_W  = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int OP_W   = 3;
    localparam int DATA_W = 32;

    localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;

    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = '1;

    // Decision for one request, made by the pointer unit.
    typedef struct packed {
        logic              ok;
        logic              wr;          // write the pushed value to the store
        logic              rd;          // fetch the new end value from the store
        logic              first;       // push into an empty deque
        logic              copy;        // pop leaves one entry: take the other end
        logic              side_front;
        logic              empty_nxt;
        logic              full_nxt;
        logic [ADDR_W-1:0] addr;
    } t_plan;

endpackage

// File: rtl/cdq_if.sv
// Request and response channel interfaces of the circular deque core.
interface cdq_req_if;
    import cdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] data_value;

    modport source (output valid, output opcode, output data_value, input ready);
    modport sink   (input valid, input opcode, input data_value, output ready);
endinterface

interface cdq_rsp_if;
    import cdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     success;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;

    modport source (output valid, output success, output front_value, output rear_value,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input success, input front_value, input rear_value,
                    input is_empty, input is_full, output ready);
endinterface

// File: rtl/cdq_ram.sv
// Generic single-port synchronous RAM with registered read data.
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/cdq_ptr.sv
// Head, tail, count and capacity registers with the per-request decision logic.
module cdq_ptr (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [cdq_pkg::CAP_W-1:0] i_cfg_wr_data,
    input  logic                      i_exec,
    input  logic [cdq_pkg::OP_W-1:0]  i_op,
    output cdq_pkg::t_plan            o_plan
);
    import cdq_pkg::*;

    logic [CNT_W-1:0]  r_cap;
    logic [ADDR_W-1:0] r_head;
    logic [ADDR_W-1:0] r_tail;
    logic [CNT_W-1:0]  r_cnt;

    logic [ADDR_W-1:0] n_head;
    logic [ADDR_W-1:0] n_tail;
    logic [CNT_W-1:0]  n_cnt;
    logic [CNT_W-1:0]  n_cap;
    logic [CMP_W-1:0]  w_cfg_ext;
    logic              w_full;
    logic              w_zero;
    logic              w_one;
    logic              w_two;
    t_plan             w_plan;

    function automatic logic [ADDR_W-1:0] step_up(input logic [ADDR_W-1:0] idx,
                                                  input logic [CNT_W-1:0]  cap);
        logic [CNT_W-1:0] inc;
        inc = CNT_W'(idx) + CNT_W'(1);
        return (inc >= cap) ? '0 : ADDR_W'(inc);
    endfunction

    function automatic logic [ADDR_W-1:0] step_down(input logic [ADDR_W-1:0] idx,
                                                    input logic [CNT_W-1:0]  cap);
        return (idx == '0) ? ADDR_W'(cap - CNT_W'(1)) : idx - ADDR_W'(1);
    endfunction

    // Zero reads as one, anything above the store depth saturates.
    always_comb begin
        w_cfg_ext = CMP_W'(i_cfg_wr_data);
        if (w_cfg_ext == '0) begin
            n_cap = CNT_W'(1);
        end else if (w_cfg_ext > CMP_W'(DEPTH)) begin
            n_cap = CNT_W'(DEPTH);
        end else begin
            n_cap = CNT_W'(w_cfg_ext);
        end
    end

    always_comb begin
        w_full = (r_cnt >= r_cap);
        w_zero = (r_cnt == '0);
        w_one  = (r_cnt == CNT_W'(1));
        w_two  = (r_cnt == CNT_W'(2));
        n_head = r_head;
        n_tail = r_tail;
        n_cnt  = r_cnt;
        w_plan = '0;
        w_plan.side_front = (i_op == OP_PUSH_FRONT) || (i_op == OP_POP_FRONT);
        unique case (i_op)
            OP_NONE: begin
                w_plan.ok = 1'b1;
            end
            OP_PUSH_FRONT: begin
                if (!w_full) begin
                    n_head = step_down(r_head, r_cap);
                    if (w_zero) begin
                        n_tail = n_head;
                    end
                    n_cnt        = r_cnt + CNT_W'(1);
                    w_plan.ok    = 1'b1;
                    w_plan.wr    = 1'b1;
                    w_plan.first = w_zero;
                end
            end
            OP_PUSH_BACK: begin
                if (!w_full) begin
                    n_tail = step_up(r_tail, r_cap);
                    if (w_zero) begin
                        n_head = n_tail;
                    end
                    n_cnt        = r_cnt + CNT_W'(1);
                    w_plan.ok    = 1'b1;
                    w_plan.wr    = 1'b1;
                    w_plan.first = w_zero;
                end
            end
            OP_POP_FRONT: begin
                if (!w_zero) begin
                    n_head      = step_up(r_head, r_cap);
                    n_cnt       = r_cnt - CNT_W'(1);
                    w_plan.ok   = 1'b1;
                    w_plan.copy = w_two;
                    w_plan.rd   = !w_one && !w_two;
                end
            end
            OP_POP_BACK: begin
                if (!w_zero) begin
                    n_tail      = step_down(r_tail, r_cap);
                    n_cnt       = r_cnt - CNT_W'(1);
                    w_plan.ok   = 1'b1;
                    w_plan.copy = w_two;
                    w_plan.rd   = !w_one && !w_two;
                end
            end
            default: begin
                w_plan.ok = 1'b0;
            end
        endcase
        w_plan.addr      = w_plan.side_front ? n_head : n_tail;
        w_plan.empty_nxt = (n_cnt == '0);
        w_plan.full_nxt  = (n_cnt >= r_cap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CNT_W'(DEPTH);
            r_head <= '0;
            r_tail <= ADDR_W'(DEPTH - 1);
            r_cnt  <= '0;
        end else if (i_cfg_wr_en) begin
            r_cap  <= n_cap;
            r_head <= '0;
            r_tail <= ADDR_W'(n_cap - CNT_W'(1));
            r_cnt  <= '0;
        end else if (i_exec) begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
        end
    end

    assign o_plan = w_plan;
endmodule

// File: rtl/circular_deque_core.sv
// Top level of the circular deque core: request sequencing, end-value cache, response register.
`include "circular_deque_core_defines.svh"

// Double-ended queue of up to 1024 signed 32-bit words in a single-port ring store,
// one response per request. A no-op, a push, a failed request, or a pop that leaves
// at most one entry answers directly; a pop leaving two or more entries goes through
// the read state to fetch the new front or rear word from the store, whose read data
// is registered (the other end values live in registers). The response sits in an
// output register; one request may be taken and parked while it waits, after which
// requests pause until the response is taken. Writing the capacity register empties
// the deque; the user must write it only while no request is in flight (not enforced).
// Reset needs no clearing pass: store words are read only after they have been written.
module circular_deque_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [cdq_pkg::CAP_W-1:0] i_cfg_wr_data,
    cdq_req_if.sink                   i_req,
    cdq_rsp_if.source                 o_rsp
);
    import cdq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PEND,
        S_READ
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic [OP_W-1:0]          r_op;
    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] r_front;
    logic signed [DATA_W-1:0] r_rear;
    logic signed [DATA_W-1:0] n_front;
    logic signed [DATA_W-1:0] n_rear;
    logic                     r_rd_front;
    logic                     r_out_valid;
    logic                     r_out_success;
    logic signed [DATA_W-1:0] r_out_front;
    logic signed [DATA_W-1:0] r_out_rear;
    logic                     r_out_empty;
    logic                     r_out_full;
    logic                     n_out_success;
    logic                     n_out_empty;
    logic                     n_out_full;

    logic                     w_out_free;
    logic                     w_take;
    logic                     w_exec;
    logic                     w_load;
    logic [OP_W-1:0]          w_cur_op;
    logic signed [DATA_W-1:0] w_cur_val;
    logic [DATA_W-1:0]        w_rdata;
    logic                     w_ram_we;
    logic                     w_ram_re;
    t_plan                    w_plan;

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_take      = i_req.valid && i_req.ready;
    assign w_cur_op    = (r_state == S_PEND) ? r_op  : i_req.opcode;
    assign w_cur_val   = (r_state == S_PEND) ? r_val : i_req.data_value;
    assign w_exec      = w_out_free && ((r_state == S_IDLE && w_take) || r_state == S_PEND);
    assign w_ram_we    = w_exec && w_plan.wr;
    assign w_ram_re    = w_exec && w_plan.rd;
    assign w_load      = (w_exec && !w_plan.rd) || (r_state == S_READ && w_out_free);

    cdq_ptr u_ptr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_exec        (w_exec),
        .i_op          (w_cur_op),
        .o_plan        (w_plan)
    );

    cdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_re    (w_ram_re),
        .i_addr  (w_plan.addr),
        .i_wdata (w_cur_val),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_front       = r_front;
        n_rear        = r_rear;
        n_out_success = w_plan.ok;
        n_out_empty   = w_plan.empty_nxt;
        n_out_full    = w_plan.full_nxt;
        unique case (r_state)
            S_IDLE, S_PEND: begin
                if (w_exec) begin
                    n_state = w_plan.rd ? S_READ : S_IDLE;
                    if (w_plan.wr) begin
                        if (w_plan.side_front || w_plan.first) begin
                            n_front = w_cur_val;
                        end
                        if (!w_plan.side_front || w_plan.first) begin
                            n_rear = w_cur_val;
                        end
                    end
                    if (w_plan.copy) begin
                        if (w_plan.side_front) begin
                            n_front = r_rear;
                        end else begin
                            n_rear = r_front;
                        end
                    end
                end else if (w_take) begin
                    // park the request until the response register frees up
                    n_state = S_PEND;
                end
            end
            S_READ: begin
                // a pop that needed the store leaves a deque neither empty nor full
                n_out_success = 1'b1;
                n_out_empty   = 1'b0;
                n_out_full    = 1'b0;
                if (w_out_free) begin
                    n_state = S_IDLE;
                    if (r_rd_front) begin
                        n_front = signed'(w_rdata);
                    end else begin
                        n_rear = signed'(w_rdata);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_take && !w_exec) begin
                r_op  <= i_req.opcode;
                r_val <= i_req.data_value;
            end
            if (w_exec) begin
                r_rd_front <= w_plan.side_front;
            end
            r_front <= n_front;
            r_rear  <= n_rear;
            if (w_load) begin
                r_out_valid   <= 1'b1;
                r_out_success <= n_out_success;
                r_out_empty   <= n_out_empty;
                r_out_full    <= n_out_full;
                r_out_front   <= n_out_empty ? EMPTY_VALUE : n_front;
                r_out_rear    <= n_out_empty ? EMPTY_VALUE : n_rear;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.success     = r_out_success;
    assign o_rsp.front_value = r_out_front;
    assign o_rsp.rear_value  = r_out_rear;
    assign o_rsp.is_empty    = r_out_empty;
    assign o_rsp.is_full     = r_out_full;

    `CDQ_ASSERT_IMP(a_empty_ends, i_clk, i_rst_n, o_rsp.valid && o_rsp.is_empty, (o_rsp.front_value == EMPTY_VALUE) && (o_rsp.rear_value == EMPTY_VALUE))
    `CDQ_ASSERT_IMP(a_not_empty_and_full, i_clk, i_rst_n, o_rsp.valid, !(o_rsp.is_empty && o_rsp.is_full))
    `CDQ_ASSERT_IMP(a_ram_one_access, i_clk, i_rst_n, w_ram_we, !w_ram_re)
    `CDQ_ASSERT_NXT(a_fetch_waits, i_clk, i_rst_n, w_ram_re, r_state == S_READ)
endmodule
